// File: sv/pvu_pkg.sv
// Package for the PML velocity node update unit.
// Holds operation codes, register indexes and the iteration stage payload.
// No dependencies.
package pvu_pkg;

  localparam int unsigned ITER_STEPS = 32;
  localparam int unsigned SQRT_STEPS = 31;

  localparam logic [1:0] CFG_TIME_STEP         = 2'd0;
  localparam logic [1:0] CFG_STEP_OVER_SPACING = 2'd1;
  localparam logic [1:0] CFG_SIDE_SIGN         = 2'd2;

  typedef enum logic [2:0] {
    OP_DAMP_SINGLE  = 3'd0,
    OP_DAMP_HARM    = 3'd1,
    OP_PLAIN_SINGLE = 3'd2,
    OP_PLAIN_HARM   = 3'd3,
    OP_SCALE        = 3'd4,
    OP_SCALE_GEO    = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_16   = 2'd1,
    SH_31   = 2'd2
  } round_shift_t;

  typedef struct packed {
    op_code_t           op;
    logic signed [31:0] v;
    logic signed [33:0] diff;
    logic [30:0]        ca;
    logic               hzero;
    logic [47:0]        hrem;
    logic [31:0]        hnum;
    logic [47:0]        hden;
    logic [31:0]        hq;
    logic [47:0]        rrem;
    logic [31:0]        rnum;
    logic [47:0]        rden;
    logic [31:0]        rq;
    logic [33:0]        srem;
    logic [61:0]        sp;
    logic [30:0]        root;
  } pvu_iter_t;

endpackage

// File: sv/pvu_if.sv
// Channel interfaces of the PML velocity node update unit.
// Depends on nothing; payload widths follow the item fields.
interface pvu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] old_value;
  logic signed [31:0] stress_fwd_a;
  logic signed [31:0] stress_fwd_b;
  logic signed [31:0] stress_back_a;
  logic signed [31:0] stress_back_b;
  logic [30:0]        attenuation;
  logic [30:0]        coef_a;
  logic [30:0]        coef_b;

  modport source (output valid, operation, old_value, stress_fwd_a, stress_fwd_b,
                  stress_back_a, stress_back_b, attenuation, coef_a, coef_b,
                  input ready);
  modport sink (input valid, operation, old_value, stress_fwd_a, stress_fwd_b,
                stress_back_a, stress_back_b, attenuation, coef_a, coef_b,
                output ready);
endinterface

interface pvu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic               saturated;

  modport source (output valid, new_value, saturated, input ready);
  modport sink (input valid, new_value, saturated, output ready);
endinterface

// File: sv/pvu_front.sv
// Front stages: stress difference, coefficient sum and the two front products,
// then divider and square root operand setup. Depends on pvu_pkg, pvu_if.
module pvu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       time_step,
  pvu_in_if.sink            item,
  input  logic              out_ready,
  output logic              out_valid,
  output pvu_pkg::pvu_iter_t out_data
);

  logic               a_vld;
  logic               en_a;
  logic               en_b;
  pvu_pkg::op_code_t  a_op;
  logic signed [31:0] a_v;
  logic signed [33:0] a_diff;
  logic [30:0]        a_ca;
  logic [31:0]        a_hsum;
  logic [62:0]        a_gprod;
  logic [61:0]        a_pab;

  logic signed [33:0] fwd_sum;
  logic signed [33:0] back_sum;
  logic [63:0]        g_round;
  logic [47:0]        g_val;
  logic [47:0]        d_val;
  logic [63:0]        rnum;
  logic [63:0]        hnum;
  pvu_pkg::pvu_iter_t b_next;

  assign en_b       = !out_valid || out_ready;
  assign en_a       = !a_vld || en_b;
  assign item.ready = en_a;

  assign fwd_sum  = 34'(item.stress_fwd_a) + 34'(item.stress_fwd_b);
  assign back_sum = 34'(item.stress_back_a) + 34'(item.stress_back_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en_a) begin
      a_vld <= item.valid;
    end
    if (en_a) begin
      a_op    <= pvu_pkg::op_code_t'(item.operation);
      a_v     <= item.old_value;
      a_diff  <= fwd_sum - back_sum;
      a_ca    <= item.coef_a;
      a_hsum  <= 32'(item.coef_a) + 32'(item.coef_b);
      a_gprod <= 63'(time_step) * 63'(item.attenuation);
      a_pab   <= 62'(item.coef_a) * 62'(item.coef_b);
    end
  end

  assign g_round = 64'(a_gprod) + 64'd32768;
  assign g_val   = g_round[63:16];
  assign d_val   = 48'h1_0000_0000 + g_val;
  assign rnum    = 64'h8000_0000_0000_0000 + 64'(d_val >> 1);
  assign hnum    = {1'b0, a_pab, 1'b0} + 64'(a_hsum >> 1);

  always_comb begin
    b_next.op    = a_op;
    b_next.v     = a_v;
    b_next.diff  = a_diff;
    b_next.ca    = a_ca;
    b_next.hzero = (a_hsum == 32'd0);
    b_next.hrem  = {16'd0, hnum[63:32]};
    b_next.hnum  = hnum[31:0];
    b_next.hden  = {16'd0, a_hsum};
    b_next.hq    = 32'd0;
    b_next.rrem  = {16'd0, rnum[63:32]};
    b_next.rnum  = rnum[31:0];
    b_next.rden  = d_val;
    b_next.rq    = 32'd0;
    b_next.srem  = 34'd0;
    b_next.sp    = a_pab;
    b_next.root  = 31'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_b) begin
      out_valid <= a_vld;
    end
    if (en_b) begin
      out_data <= b_next;
    end
  end

endmodule

// File: sv/pvu_iter_stage.sv
// One iteration stage: one quotient bit of each divider and, below SQRT_STEPS, one root bit.
// Depends on pvu_pkg.
module pvu_iter_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pvu_pkg::pvu_iter_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pvu_pkg::pvu_iter_t out_data
);

  logic [48:0]        ht;
  logic [48:0]        rt;
  logic [33:0]        st;
  logic [33:0]        trial;
  pvu_pkg::pvu_iter_t nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt   = in_data;
    ht    = {in_data.hrem, in_data.hnum[31]};
    rt    = {in_data.rrem, in_data.rnum[31]};
    st    = {in_data.srem[31:0], in_data.sp[61:60]};
    trial = {1'b0, in_data.root, 2'b01};
    nxt.hnum = {in_data.hnum[30:0], 1'b0};
    nxt.rnum = {in_data.rnum[30:0], 1'b0};
    if (ht >= {1'b0, in_data.hden}) begin
      nxt.hrem = 48'(ht - {1'b0, in_data.hden});
      nxt.hq   = {in_data.hq[30:0], 1'b1};
    end else begin
      nxt.hrem = ht[47:0];
      nxt.hq   = {in_data.hq[30:0], 1'b0};
    end
    if (rt >= {1'b0, in_data.rden}) begin
      nxt.rrem = 48'(rt - {1'b0, in_data.rden});
      nxt.rq   = {in_data.rq[30:0], 1'b1};
    end else begin
      nxt.rrem = rt[47:0];
      nxt.rq   = {in_data.rq[30:0], 1'b0};
    end
    if (IDX < pvu_pkg::SQRT_STEPS) begin
      nxt.sp = {in_data.sp[59:0], 2'b00};
      if (st >= trial) begin
        nxt.srem = st - trial;
        nxt.root = {in_data.root[29:0], 1'b1};
      end else begin
        nxt.srem = st;
        nxt.root = {in_data.root[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

// File: sv/pvu_back.sv
// Back stages: coefficient products, stress term, damping combine, rounding and
// saturation into the output register. Depends on pvu_pkg, pvu_if.
module pvu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        step_over_spacing,
  input  logic               side_sign,
  input  logic               in_valid,
  output logic               in_ready,
  input  pvu_pkg::pvu_iter_t in_data,
  pvu_out_if.source          result
);

  logic [4:0] vld;
  logic [5:0] en;

  pvu_pkg::op_code_t  q1_op, q2_op, q3_op, q4_op;
  logic signed [31:0] q1_v, q2_v, q3_v, q4_v, q5_v;
  logic [63:0]        q1_c;
  logic signed [64:0] q1_sp, q2_sp, q3_sp;
  logic signed [33:0] q1_r1;
  logic [31:0]        q1_r2, q2_r2, q3_r2;
  logic [33:0]        q1_dm;
  logic               q1_tneg, q2_tneg, q3_tneg, q4_tneg;
  logic [65:0]        q2_pl, q2_ph;
  logic signed [65:0] q2_a;
  logic [62:0]        q3_tmag;
  logic               q3_aneg, q4_aneg;
  logic [63:0]        q3_amag, q4_amag;
  logic [63:0]        q4_bl;
  logic [62:0]        q4_bh;
  logic               q4_pneg, q4_sneg;
  logic [63:0]        q4_pmag, q4_smag;
  logic               q5_neg, q5_pass;
  logic [63:0]        q5_mag;
  pvu_pkg::round_shift_t q5_sh;

  logic               harm;
  logic [31:0]        lsel;
  logic [31:0]        fsel;
  logic [97:0]        tprod;
  logic signed [64:0] tsig;
  logic signed [64:0] psum;
  logic [95:0]        bprod;
  logic [63:0]        blo;
  logic               bneg;
  logic               dneg;
  logic [63:0]        dmag;
  logic               sel_neg;
  logic               sel_pass;
  logic [63:0]        sel_mag;
  pvu_pkg::round_shift_t sel_sh;
  logic [64:0]        rsum;
  logic [64:0]        qw;
  logic [32:0]        limit;
  logic               over;
  logic [32:0]        qsel;

  assign en[5]    = !result.valid || result.ready;
  assign en[4]    = !vld[4] || en[5];
  assign en[3]    = !vld[3] || en[4];
  assign en[2]    = !vld[2] || en[3];
  assign en[1]    = !vld[1] || en[2];
  assign en[0]    = !vld[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) result.valid <= vld[4];
    end
  end

  always_comb begin
    harm = (in_data.op == pvu_pkg::OP_DAMP_HARM) || (in_data.op == pvu_pkg::OP_PLAIN_HARM);
    if (harm) begin
      lsel = in_data.hzero ? 32'd0 : in_data.hq;
    end else begin
      lsel = {1'b0, in_data.ca};
    end
    if (in_data.op == pvu_pkg::OP_SCALE_GEO) begin
      fsel = {1'b0, in_data.root} + 32'(in_data.srem > {3'd0, in_data.root});
    end else begin
      fsel = {1'b0, in_data.ca};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q1_op   <= in_data.op;
      q1_v    <= in_data.v;
      q1_c    <= 64'(step_over_spacing) * 64'(lsel);
      q1_sp   <= 65'(in_data.v) * $signed({33'd0, fsel});
      q1_r1   <= $signed({1'b0, in_data.rq, 1'b0}) - 34'sh0_8000_0000;
      q1_r2   <= in_data.rq;
      q1_tneg <= in_data.diff < 0;
      q1_dm   <= (in_data.diff < 0) ? 34'(-in_data.diff) : 34'(in_data.diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q2_op   <= q1_op;
      q2_v    <= q1_v;
      q2_sp   <= q1_sp;
      q2_r2   <= q1_r2;
      q2_tneg <= q1_tneg;
      q2_pl   <= 66'(q1_c[31:0]) * 66'(q1_dm);
      q2_ph   <= 66'(q1_c[63:32]) * 66'(q1_dm);
      q2_a    <= 66'(q1_r1) * 66'(q1_v);
    end
  end

  assign tprod = {q2_ph, 32'd0} + 98'(q2_pl) + 98'h8000_0000;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q3_op   <= q2_op;
      q3_v    <= q2_v;
      q3_sp   <= q2_sp;
      q3_r2   <= q2_r2;
      q3_tneg <= q2_tneg;
      q3_tmag <= (tprod[97:94] != 4'd0) ? 63'h4000_0000_0000_0000 : {1'b0, tprod[93:32]};
      q3_aneg <= q2_a < 0;
      q3_amag <= (q2_a < 0) ? 64'(-q2_a) : 64'(q2_a);
    end
  end

  assign tsig = q3_tneg ? -65'(q3_tmag) : 65'(q3_tmag);
  assign psum = 65'(q3_v) + tsig;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q4_op   <= q3_op;
      q4_v    <= q3_v;
      q4_tneg <= q3_tneg;
      q4_aneg <= q3_aneg;
      q4_amag <= q3_amag;
      q4_bl   <= 64'(q3_r2) * 64'(q3_tmag[31:0]);
      q4_bh   <= 63'(q3_r2) * 63'(q3_tmag[62:32]);
      q4_pneg <= psum < 0;
      q4_pmag <= (psum < 0) ? 64'(-psum) : 64'(psum);
      q4_sneg <= q3_sp < 0;
      q4_smag <= (q3_sp < 0) ? 64'(-q3_sp) : 64'(q3_sp);
    end
  end

  assign bprod = {q4_bh[62:0], 32'd0} + 96'(q4_bl);
  assign blo   = bprod[63:0];
  assign bneg  = q4_tneg ^ side_sign;

  always_comb begin
    if (bprod[95:64] != 32'd0) begin
      dneg = bneg;
      dmag = '1;
    end else if (q4_aneg == bneg) begin
      dneg = bneg;
      dmag = (blo > 64'h8000_0000_0000_0000) ? '1 : q4_amag + blo;
    end else if (blo >= q4_amag) begin
      dneg = bneg;
      dmag = blo - q4_amag;
    end else begin
      dneg = q4_aneg;
      dmag = q4_amag - blo;
    end
    sel_pass = 1'b0;
    case (q4_op)
      pvu_pkg::OP_DAMP_SINGLE, pvu_pkg::OP_DAMP_HARM: begin
        sel_neg = dneg;
        sel_mag = dmag;
        sel_sh  = pvu_pkg::SH_31;
      end
      pvu_pkg::OP_PLAIN_SINGLE, pvu_pkg::OP_PLAIN_HARM: begin
        sel_neg = q4_pneg;
        sel_mag = q4_pmag;
        sel_sh  = pvu_pkg::SH_NONE;
      end
      pvu_pkg::OP_SCALE, pvu_pkg::OP_SCALE_GEO: begin
        sel_neg = q4_sneg;
        sel_mag = q4_smag;
        sel_sh  = pvu_pkg::SH_16;
      end
      default: begin
        sel_neg  = 1'b0;
        sel_mag  = '0;
        sel_sh   = pvu_pkg::SH_NONE;
        sel_pass = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      q5_v    <= q4_v;
      q5_neg  <= sel_neg;
      q5_mag  <= sel_mag;
      q5_sh   <= sel_sh;
      q5_pass <= sel_pass;
    end
  end

  always_comb begin
    case (q5_sh)
      pvu_pkg::SH_16: begin
        rsum = {1'b0, q5_mag} + 65'h8000;
        qw   = rsum >> 16;
      end
      pvu_pkg::SH_31: begin
        rsum = {1'b0, q5_mag} + 65'h4000_0000;
        qw   = rsum >> 31;
      end
      default: begin
        rsum = {1'b0, q5_mag};
        qw   = rsum;
      end
    endcase
    limit = q5_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    over  = (q5_mag > 64'h8000_0000_0000_0000) || (qw > 65'(limit));
    qsel  = over ? limit : qw[32:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (q5_pass) begin
        result.new_value <= q5_v;
        result.saturated <= 1'b0;
      end else begin
        result.new_value <= q5_neg ? 32'(-qsel) : 32'(qsel);
        result.saturated <= over;
      end
    end
  end

endmodule

// File: sv/pml_velocity_node_update_unit.sv
// Top level of the PML velocity node update unit: configuration registers,
// front stages, 32 iteration stages and back stages. Depends on pvu_pkg, pvu_if.
//
//   channel      role    handshake       payload
//   item_in      sink    valid / ready   operation, old value, stresses, coefs
//   result_out   source  valid / ready   new_value, saturated
//   cfg          write   cfg_wr_en       cfg_index, cfg_data
//
// One item per cycle while the output is ready (2 front, 32 divide/root, 6 back stages).
// The 32 one-bit divider stages, all but the last also taking a square root bit, set the depth.
// Every stage holds its own valid bit and stalls only when the stage after it is
// full and held, so bubbles close up and nothing is dropped or repeated.
// rst clears all valid bits; pipeline data registers are not reset.
module pml_velocity_node_update_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pvu_in_if.sink      item_in,
  pvu_out_if.source   result_out
);

  logic [31:0] time_step;
  logic [31:0] step_over_spacing;
  logic        side_sign;

  logic               st_valid [pvu_pkg::ITER_STEPS+1];
  logic               st_ready [pvu_pkg::ITER_STEPS+1];
  pvu_pkg::pvu_iter_t st_data  [pvu_pkg::ITER_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= '0;
      step_over_spacing <= '0;
      side_sign         <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pvu_pkg::CFG_TIME_STEP:         time_step         <= cfg_data;
        pvu_pkg::CFG_STEP_OVER_SPACING: step_over_spacing <= cfg_data;
        pvu_pkg::CFG_SIDE_SIGN:         side_sign         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pvu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .time_step (time_step),
    .item      (item_in),
    .out_ready (st_ready[0]),
    .out_valid (st_valid[0]),
    .out_data  (st_data[0])
  );

  for (genvar k = 0; k < pvu_pkg::ITER_STEPS; k++) begin : g_iter
    pvu_iter_stage #(.IDX(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_data   (st_data[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_data  (st_data[k+1])
    );
  end

  pvu_back u_back (
    .clk               (clk),
    .rst               (rst),
    .step_over_spacing (step_over_spacing),
    .side_sign         (side_sign),
    .in_valid          (st_valid[pvu_pkg::ITER_STEPS]),
    .in_ready          (st_ready[pvu_pkg::ITER_STEPS]),
    .in_data           (st_data[pvu_pkg::ITER_STEPS]),
    .result            (result_out)
  );

`ifndef SYNTHESIS
  a_sat_is_limit: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.saturated |->
      (result_out.new_value == 32'sh7FFF_FFFF) || (result_out.new_value == 32'sh8000_0000))
    else $error("saturated result is not a range limit");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_out.valid |-> item_in.ready)
    else $error("input stalled while output register is empty");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("output valid after reset");
`endif

endmodule

// File: test/testbench.sv
// Testbench for pml_velocity_node_update_unit: directed and random node updates
// checked in order against a fixed-point velocity update predictor.
// Depends on pvu_pkg, pvu_if and the unit's top level.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 147;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0]  operation;
    logic [31:0] old_value;
    logic [31:0] fwd_a;
    logic [31:0] fwd_b;
    logic [31:0] back_a;
    logic [31:0] back_b;
    logic [30:0] attenuation;
    logic [30:0] coef_a;
    logic [30:0] coef_b;
  } node_item_t;

  typedef struct {
    logic [31:0] new_value;
    logic        saturated;
  } velocity_t;

  class velocity_scoreboard;
    bit [31:0] time_step;
    bit [31:0] step_over_spacing;
    bit        side_sign;
    velocity_t pending_q[$];
    int        mismatches;

    static function bit [63:0] mag64(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    static function bit [63:0] sqrt_round(bit [63:0] p);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > p) b = b >> 2;
      while (b != 0) begin
        if (p >= r + b) begin
          p = p - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return p > r ? r + 1 : r;
    endfunction

    static function velocity_t round_out(bit neg, bit [63:0] mag, int sh);
      velocity_t res;
      bit [63:0] q;
      bit [63:0] lim;
      if (mag > 64'h8000_0000_0000_0000) q = 64'h1_0000_0000;
      else q = (mag + (sh != 0 ? 64'd1 << (sh - 1) : 64'd0)) >> sh;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      res.saturated = q > lim;
      if (q > lim) q = lim;
      q = neg ? 64'd0 - q : q;
      res.new_value = q[31:0];
      return res;
    endfunction

    function velocity_t update_velocity(node_item_t it);
      longint v, dif, t, sum, r1, a;
      bit [63:0] att, ca, cb, f, s, lc, c, dmag, tmag, g, d, r2, amag, blo;
      bit [127:0] w;
      bit tneg, aneg, bneg;
      v = longint'($signed(it.old_value));
      dif = (longint'($signed(it.fwd_a)) + longint'($signed(it.fwd_b)))
          - (longint'($signed(it.back_a)) + longint'($signed(it.back_b)));
      att = it.attenuation;
      ca = it.coef_a;
      cb = it.coef_b;
      if (it.operation > pvu_pkg::OP_SCALE_GEO)
        return '{it.old_value, 1'b0};
      if (it.operation >= pvu_pkg::OP_SCALE) begin
        f = (it.operation == pvu_pkg::OP_SCALE) ? ca : sqrt_round(ca * cb);
        t = v * longint'(f);
        return round_out(t < 0, mag64(t), 16);
      end
      if (it.operation == pvu_pkg::OP_DAMP_SINGLE ||
          it.operation == pvu_pkg::OP_PLAIN_SINGLE) begin
        lc = ca;
      end else begin
        s = ca + cb;
        lc = (s == 0) ? 64'd0 : (64'd2 * ca * cb + s / 2) / s;
      end
      c = 64'(step_over_spacing) * lc;
      tneg = dif < 0;
      dmag = mag64(dif);
      w = {64'd0, c} * {64'd0, dmag} + 128'h8000_0000;
      tmag = (w[127:94] != 0) ? 64'd1 << 62 : w[95:32];
      if (it.operation >= pvu_pkg::OP_PLAIN_SINGLE) begin
        t = tneg ? -longint'(tmag) : longint'(tmag);
        sum = v + t;
        return round_out(sum < 0, mag64(sum), 0);
      end
      g = (64'(time_step) * att + 64'h8000) >> 16;
      d = 64'h1_0000_0000 + g;
      r2 = (64'h8000_0000_0000_0000 + d / 2) / d;
      r1 = 2 * longint'(r2) - longint'(64'h8000_0000);
      a = r1 * v;
      aneg = a < 0;
      amag = mag64(a);
      bneg = tneg != side_sign;
      w = {64'd0, r2} * {64'd0, tmag};
      blo = w[63:0];
      if (w[127:64] != 0) return round_out(bneg, '1, 31);
      if (aneg == bneg)
        return round_out(bneg, (blo > 64'h8000_0000_0000_0000) ? '1 : amag + blo, 31);
      if (blo >= amag) return round_out(bneg, blo - amag, 31);
      return round_out(aneg, amag - blo, 31);
    endfunction

    function void note_input(node_item_t it);
      pending_q.push_back(update_velocity(it));
    endfunction

    function void check_result(logic [31:0] nv, logic sat);
      velocity_t exp_v;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: new_value=%h saturated=%b", nv, sat);
        return;
      end
      exp_v = pending_q.pop_front();
      if (nv !== exp_v.new_value || sat !== exp_v.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected new_value=%h saturated=%b, got %h %b",
                   exp_v.new_value, exp_v.saturated, nv, sat);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pvu_in_if  item_in();
  pvu_out_if result_out();

  pml_velocity_node_update_unit u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item_in(item_in), .result_out(result_out)
  );

  velocity_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_in.valid = 1'b0;
    item_in.operation = '0;
    item_in.old_value = '0;
    item_in.stress_fwd_a = '0;
    item_in.stress_fwd_b = '0;
    item_in.stress_back_a = '0;
    item_in.stress_back_b = '0;
    item_in.attenuation = '0;
    item_in.coef_a = '0;
    item_in.coef_b = '0;
    result_out.ready = 1'b0;
  end

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst) begin
      if (result_out.valid && result_out.ready)
        sb.check_result(result_out.new_value, result_out.saturated);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_in.valid && item_in.ready) || (result_out.valid && result_out.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      pvu_pkg::CFG_TIME_STEP: sb.time_step = data;
      pvu_pkg::CFG_STEP_OVER_SPACING: sb.step_over_spacing = data;
      default: sb.side_sign = data[0];
    endcase
  endtask

  task automatic set_config(logic [31:0] dt, logic [31:0] k, logic side);
    write_reg(pvu_pkg::CFG_TIME_STEP, dt);
    write_reg(pvu_pkg::CFG_STEP_OVER_SPACING, k);
    write_reg(pvu_pkg::CFG_SIDE_SIGN, {31'd0, side});
  endtask

  task automatic send_item(node_item_t it);
    item_in.valid <= 1'b1;
    item_in.operation <= it.operation;
    item_in.old_value <= it.old_value;
    item_in.stress_fwd_a <= it.fwd_a;
    item_in.stress_fwd_b <= it.fwd_b;
    item_in.stress_back_a <= it.back_a;
    item_in.stress_back_b <= it.back_b;
    item_in.attenuation <= it.attenuation;
    item_in.coef_a <= it.coef_a;
    item_in.coef_b <= it.coef_b;
    do @(posedge clk); while (!item_in.ready);
    sb.note_input(it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    item_in.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
    endcase
  endfunction

  function automatic node_item_t rand_item();
    node_item_t it;
    it.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
    it.old_value = rand_q16();
    it.fwd_a = rand_q16();
    it.fwd_b = rand_q16();
    it.back_a = rand_q16();
    it.back_b = rand_q16();
    it.attenuation = $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                : 31'($urandom_range(0, 32'h0010_0000));
    it.coef_a = rand_coef();
    it.coef_b = rand_coef();
    return it;
  endfunction

  initial begin
    node_item_t it;
    int ph;
    sb = new();
    send_idle_pct = 16;
    recv_idle_pct = 55;
    hold_request = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_config(32'h0100_0000, 32'h0000_8000, 1'b0);

    // directed: every operation, field extremes, zero coefficients
    for (int op = 0; op < 8; op++) begin
      it = '{3'(op), 32'h0001_8000, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_0000,
             32'h0000_1000, 31'h0001_0000, 31'h0001_8000, 31'h0000_C000};
      send_item(it);
    end
    it = '{pvu_pkg::OP_DAMP_HARM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    send_item(it);
    it = '{pvu_pkg::OP_DAMP_SINGLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF, 31'h1};
    send_item(it);
    it = '{pvu_pkg::OP_PLAIN_HARM, 32'h1234_5678, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
           31'h0, 31'h0, 31'h0};
    send_item(it);
    it.coef_a = 31'h0001_0000;
    send_item(it);
    it = '{pvu_pkg::OP_PLAIN_SINGLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h8000_0000, 31'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    send_item(it);
    it = '{pvu_pkg::OP_SCALE_GEO, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0,
           31'h7FFF_FFFF, 31'h7FFF_FFFF};
    send_item(it);
    it = '{pvu_pkg::OP_SCALE, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0,
           31'h0001_0000, 31'h1};
    send_item(it);
    it = '{OP_UNUSED_HI, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF,
           31'h0, 31'h0};
    send_item(it);
    it.operation = OP_UNUSED_LO;
    send_item(it);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(32'h0, 32'h0, 1'b0);
        1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        2: set_config($urandom(), $urandom(), 1'b1);
        default: set_config($urandom_range(0, 32'h0400_0000),
                            $urandom_range(32'h0000_1000, 32'h0002_0000), 1'($urandom()));
      endcase
      send_idle_pct = (ph < 3) ? 16 : (ph < 5) ? 55 : 0;
      recv_idle_pct = (ph < 3) ? 55 : (ph < 5) ? 16 : 0;
      if (ph == 1 || ph == 5) hold_request++;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(rand_item());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
